### hw/rtl/lcd_parallel_bus_sequencer_core_defines.svh
// Assertion macros shared by the sequencer RTL.
// Each module that uses them has i_clk and i_rst_n in scope.
`ifndef LCD_PARALLEL_BUS_SEQUENCER_CORE_DEFINES_SVH
`define LCD_PARALLEL_BUS_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LPBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define LPBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/lcdpbs_pkg.sv
`timescale 1ns / 1ps

package lcdpbs_pkg;

    // Command kinds
    localparam logic [2:0] MODE_INSTR  = 3'd0;
    localparam logic [2:0] MODE_DATA   = 3'd1;
    localparam logic [2:0] MODE_CURSOR = 3'd2;
    localparam logic [2:0] MODE_CLEAR  = 3'd3;
    localparam logic [2:0] MODE_INIT   = 3'd4;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BUS_FOUR_BIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_HOLD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_UP_WAIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_CLR_EXTRA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLR_EXTRA      = 3'd4;

    // Configuration reset values
    localparam logic        RST_BUS_FOUR_BIT   = 1'b1;
    localparam logic [15:0] RST_PULSE_HOLD     = 16'd1000;
    localparam logic [15:0] RST_POWER_UP_WAIT  = 16'd50000;
    localparam logic [15:0] RST_INIT_CLR_EXTRA = 16'd1000;
    localparam logic [15:0] RST_CLR_EXTRA      = 16'd2000;

    // Controller instruction bytes
    localparam logic [7:0] INS_FUNC_8BIT   = 8'h38;
    localparam logic [7:0] INS_DISPLAY_ON  = 8'h0C;
    localparam logic [7:0] INS_CLEAR       = 8'h01;
    localparam logic [7:0] INS_ENTRY_MODE  = 8'h06;
    localparam logic [7:0] INS_HOME        = 8'h02;
    localparam logic [7:0] INS_FUNC_4BIT   = 8'h28;
    localparam logic [7:0] INS_SET_DDRAM   = 8'h80;
    localparam logic [6:0] LINE1_OFFSET    = 7'h40;

    // Byte positions within the initialization run
    localparam logic [2:0] INIT_LAST_4BIT  = 3'd4;
    localparam logic [2:0] INIT_LAST_8BIT  = 3'd3;
    localparam logic [2:0] INIT_CLR_4BIT   = 3'd3;
    localparam logic [2:0] INIT_CLR_8BIT   = 3'd2;

    typedef struct packed {
        logic       cap;        // latch the accepted command
        logic       emit_wait;  // load the power-up wait beat
        logic       emit_pulse; // load a bus beat
        logic       last;       // final beat of the command
        logic       byte_end;   // final enable-low beat of a byte
        logic [2:0] bidx;       // byte position within the command
        logic [1:0] phase;      // beat position within the byte
    } t_cmd;

    typedef struct packed {
        logic out_free;  // output register can take a beat
        logic four;      // 4-bit bus selected
        logic empty;     // command produces no beats
        logic init;      // command is an initialization run
        logic last_byte; // current byte is the final one
    } t_sts;

    // Byte sent at position bidx of a command
    function automatic logic [7:0] byte_of(input logic [2:0] mode, input logic four,
                                           input logic [2:0] bidx, input logic [7:0] value,
                                           input logic [6:0] addr);
        logic [7:0] b;
        b = value;
        unique case (mode)
            MODE_CURSOR: b = INS_SET_DDRAM | {1'b0, addr};
            MODE_CLEAR:  b = INS_CLEAR;
            MODE_INIT: begin
                if (four) begin
                    unique case (bidx)
                        3'd0:    b = INS_HOME;
                        3'd1:    b = INS_FUNC_4BIT;
                        3'd2:    b = INS_DISPLAY_ON;
                        3'd3:    b = INS_CLEAR;
                        default: b = INS_ENTRY_MODE;
                    endcase
                end else begin
                    unique case (bidx)
                        3'd0:    b = INS_FUNC_8BIT;
                        3'd1:    b = INS_DISPLAY_ON;
                        3'd2:    b = INS_CLEAR;
                        default: b = INS_ENTRY_MODE;
                    endcase
                end
            end
            default: b = value;
        endcase
        return b;
    endfunction

endpackage

### hw/rtl/lcd_parallel_bus_sequencer_core.sv
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// -------   -----------------------   ------------------------------------------
// command   i_in_valid / o_in_ready   i_mode, i_value, i_line, i_column
// pin beat  o_out_valid / i_out_ready o_reg_select, o_data_pins, o_enable,
//                                     o_hold_us, o_last
// config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One command at a time: accepted in idle, decoded in the next cycle, then one pin
// beat per cycle while the output register drains. A 4-bit initialization run
// sends 21 beats; a byte is sent as two beats (8-bit bus) or four (4-bit bus).
// Commands that produce no beats return to idle after the decode cycle.
// A stalled output holds the beat register and the sequencer with it.
// Synchronous active-low reset restores the configuration defaults and idles.
// Config writes are always taken; write them only while the block is idle.

module lcd_parallel_bus_sequencer_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [2:0]                       i_mode,
    input  logic [7:0]                       i_value,
    input  logic [7:0]                       i_line,
    input  logic [6:0]                       i_column,
    // pin beats
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_reg_select,
    output logic [7:0]                       o_data_pins,
    output logic                             o_enable,
    output logic [15:0]                      o_hold_us,
    output logic                             o_last,
    // configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lcdpbs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                      i_cfg_data
);

    lcdpbs_pkg::t_cmd cmd;
    lcdpbs_pkg::t_sts sts;

    // config port never stalls
    assign o_cfg_ready = 1'b1;

    // sequencer: walks bytes and beats, gates each beat on a free output slot
    lcdpbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: config registers, command latch, byte select, hold add, beat register
    lcdpbs_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_mode       (i_mode),
        .i_value      (i_value),
        .i_line       (i_line),
        .i_column     (i_column),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_reg_select (o_reg_select),
        .o_data_pins  (o_data_pins),
        .o_enable     (o_enable),
        .o_hold_us    (o_hold_us),
        .o_last       (o_last)
    );

endmodule

### hw/rtl/lcdpbs_dp.sv
`timescale 1ns / 1ps
`include "lcd_parallel_bus_sequencer_core_defines.svh"

module lcdpbs_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lcdpbs_pkg::t_cmd                i_cmd,
    output lcdpbs_pkg::t_sts                o_sts,
    input  logic [2:0]                      i_mode,
    input  logic [7:0]                      i_value,
    input  logic [7:0]                      i_line,
    input  logic [6:0]                      i_column,
    input  logic                            i_cfg_valid,
    input  logic [lcdpbs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                     i_cfg_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_reg_select,
    output logic [7:0]                      o_data_pins,
    output logic                            o_enable,
    output logic [15:0]                     o_hold_us,
    output logic                            o_last
);

    // configuration
    logic        r_four;
    logic [15:0] r_pulse;
    logic [15:0] r_pwait;
    logic [15:0] r_iclr;
    logic [15:0] r_clr;

    // latched command
    logic [2:0] r_mode;
    logic [7:0] r_value;
    logic [7:0] r_line;
    logic [6:0] r_column;

    // output beat
    logic        r_valid;
    logic        r_rs;
    logic [7:0]  r_pins;
    logic        r_en;
    logic [15:0] r_hold;
    logic        r_last;

    logic [6:0]  addr;
    logic [7:0]  cur_byte;
    logic [7:0]  n_pins;
    logic [15:0] extra;
    logic [16:0] hold_sum;
    logic [15:0] n_hold;
    logic        is_init_clr;
    logic        load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four  <= lcdpbs_pkg::RST_BUS_FOUR_BIT;
            r_pulse <= lcdpbs_pkg::RST_PULSE_HOLD;
            r_pwait <= lcdpbs_pkg::RST_POWER_UP_WAIT;
            r_iclr  <= lcdpbs_pkg::RST_INIT_CLR_EXTRA;
            r_clr   <= lcdpbs_pkg::RST_CLR_EXTRA;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lcdpbs_pkg::CFG_BUS_FOUR_BIT:   r_four  <= i_cfg_data[0];
                lcdpbs_pkg::CFG_PULSE_HOLD:     r_pulse <= i_cfg_data;
                lcdpbs_pkg::CFG_POWER_UP_WAIT:  r_pwait <= i_cfg_data;
                lcdpbs_pkg::CFG_INIT_CLR_EXTRA: r_iclr  <= i_cfg_data;
                lcdpbs_pkg::CFG_CLR_EXTRA:      r_clr   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_mode   <= i_mode;
            r_value  <= i_value;
            r_line   <= i_line;
            r_column <= i_column;
        end
    end

    assign addr = r_line[0] ? (r_column + lcdpbs_pkg::LINE1_OFFSET) : r_column;
    assign cur_byte = lcdpbs_pkg::byte_of(r_mode, r_four, i_cmd.bidx, r_value, addr);

    always_comb begin
        if (!r_four)
            n_pins = cur_byte;
        else if (!i_cmd.phase[1])
            n_pins = {cur_byte[7:4], 4'h0};
        else
            n_pins = {cur_byte[3:0], 4'h0};
    end

    assign is_init_clr = (r_mode == lcdpbs_pkg::MODE_INIT) &&
                         (i_cmd.bidx == (r_four ? lcdpbs_pkg::INIT_CLR_4BIT
                                                : lcdpbs_pkg::INIT_CLR_8BIT));

    always_comb begin
        extra = 16'd0;
        if (i_cmd.byte_end) begin
            if (r_mode == lcdpbs_pkg::MODE_CLEAR)
                extra = r_clr;
            else if (is_init_clr)
                extra = r_iclr;
        end
    end

    assign hold_sum = {1'b0, r_pulse} + {1'b0, extra};
    assign n_hold   = hold_sum[16] ? 16'hFFFF : hold_sum[15:0];
    assign load     = i_cmd.emit_wait | i_cmd.emit_pulse;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_valid <= 1'b0;
        else if (load)
            r_valid <= 1'b1;
        else if (i_out_ready)
            r_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_wait) begin
            r_rs   <= 1'b0;
            r_pins <= 8'h00;
            r_en   <= 1'b0;
            r_hold <= r_pwait;
            r_last <= 1'b0;
        end else if (i_cmd.emit_pulse) begin
            r_rs   <= (r_mode == lcdpbs_pkg::MODE_DATA);
            r_pins <= n_pins;
            r_en   <= ~i_cmd.phase[0];
            r_hold <= n_hold;
            r_last <= i_cmd.last;
        end
    end

    always_comb begin
        o_sts.out_free  = ~r_valid | i_out_ready;
        o_sts.four      = r_four;
        o_sts.init      = (r_mode == lcdpbs_pkg::MODE_INIT);
        o_sts.empty     = (r_mode > lcdpbs_pkg::MODE_INIT) ||
                          ((r_mode == lcdpbs_pkg::MODE_CURSOR) && (r_line > 8'd1));
        if (r_mode == lcdpbs_pkg::MODE_INIT)
            o_sts.last_byte = (i_cmd.bidx == (r_four ? lcdpbs_pkg::INIT_LAST_4BIT
                                                     : lcdpbs_pkg::INIT_LAST_8BIT));
        else
            o_sts.last_byte = (i_cmd.bidx == 3'd0);
    end

    assign o_out_valid  = r_valid;
    assign o_reg_select = r_rs;
    assign o_data_pins  = r_pins;
    assign o_enable     = r_en;
    assign o_hold_us    = r_hold;
    assign o_last       = r_last;

    // nibble beats never drive the low data lines
    `LPBS_ASSERT_NOW(a_nibble_low_zero, r_valid && r_four && !r_last && r_rs,
        r_pins[3:0] == 4'h0, "4-bit beat drives D3..D0")

endmodule

### hw/rtl/lcdpbs_ctrl.sv
`timescale 1ns / 1ps
`include "lcd_parallel_bus_sequencer_core_defines.svh"

module lcdpbs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lcdpbs_pkg::t_sts i_sts,
    output lcdpbs_pkg::t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DEC  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_BYTE = 2'd3;

    logic [1:0] r_state, n_state;
    logic [2:0] r_bidx, n_bidx;
    logic [1:0] r_phase, n_phase;
    logic       phase_end;
    logic       accept;

    assign accept    = i_in_valid && (r_state == ST_IDLE);
    assign phase_end = i_sts.four ? (r_phase == 2'd3) : (r_phase == 2'd1);

    always_comb begin
        n_state = r_state;
        n_bidx  = r_bidx;
        n_phase = r_phase;
        o_cmd   = '0;
        o_cmd.bidx     = r_bidx;
        o_cmd.phase    = r_phase;
        o_cmd.byte_end = phase_end;
        o_cmd.last     = phase_end && i_sts.last_byte;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = ST_DEC;
                end
            end
            ST_DEC: begin
                n_bidx  = 3'd0;
                n_phase = 2'd0;
                if (i_sts.empty)
                    n_state = ST_IDLE;
                else if (i_sts.init)
                    n_state = ST_WAIT;
                else
                    n_state = ST_BYTE;
            end
            ST_WAIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_wait = 1'b1;
                    n_state         = ST_BYTE;
                end
            end
            default: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_pulse = 1'b1;
                    if (!phase_end) begin
                        n_phase = r_phase + 2'd1;
                    end else if (i_sts.last_byte) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_bidx  = r_bidx + 3'd1;
                        n_phase = 2'd0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_bidx  <= 3'd0;
            r_phase <= 2'd0;
        end else begin
            r_state <= n_state;
            r_bidx  <= n_bidx;
            r_phase <= n_phase;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    `LPBS_ASSERT_NOW(a_emit_needs_slot, o_cmd.emit_pulse || o_cmd.emit_wait,
        i_sts.out_free, "beat loaded over an untaken one")
    `LPBS_ASSERT_NOW(a_8bit_two_beats, (r_state == ST_BYTE) && !i_sts.four,
        !r_phase[1], "8-bit byte runs past two beats")
    `LPBS_ASSERT_NEXT(a_accept_decodes, accept,
        r_state == ST_DEC, "accepted command not decoded next cycle")
    `LPBS_ASSERT_NEXT(a_last_returns_idle, o_cmd.emit_pulse && o_cmd.last,
        r_state == ST_IDLE, "sequencer busy after the final beat")

endmodule
